[hw/rtl/wpm_pkg.sv]
package wpm_pkg;

  localparam int MAX_PATTERN = 128;
  localparam int IDX_W = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_ANY = 8'h3F;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic advance;
    logic restart;
    logic wr;
    logic [7:0] sym;
    idx_t len;
    idx_t len_next;
  } ctl_t;

  typedef struct packed {
    logic step;
    logic close;
    logic star_first;
  } link_t;

endpackage

[hw/rtl/wpm_cell.sv]
module wpm_cell (
  input  logic           clk,
  input  logic           rst,
  input  wpm_pkg::idx_t  idx,
  input  wpm_pkg::ctl_t  ctl,
  input  wpm_pkg::link_t left,
  output wpm_pkg::link_t right,
  output logic           act
);

  logic [7:0] p;
  logic [7:0] p_next;
  logic       used;
  logic       used_next;
  logic       st;
  logic       we;
  logic       pre;
  logic       post;
  logic       act_next;

  assign used = idx < ctl.len;
  assign used_next = idx < ctl.len_next;
  assign st = used && (p == wpm_pkg::SYM_STAR);
  assign we = ctl.wr && (idx == ctl.len);
  assign p_next = we ? ctl.sym : p;

  assign pre = (act && st) || left.step;
  assign post = pre || left.close;

  assign right.step = act && used && !st && ((p == wpm_pkg::SYM_ANY) || (p == ctl.sym));
  assign right.close = pre && st;
  assign right.star_first = (idx == '0) && used_next && (p_next == wpm_pkg::SYM_STAR);

  always_comb begin
    act_next = act;
    if (ctl.restart) begin
      act_next = (idx == '0) || left.star_first;
    end else if (ctl.advance) begin
      act_next = post;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= (idx == '0);
    end else begin
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      p <= ctl.sym;
    end
  end

endmodule

[hw/rtl/wildcard_pattern_match.sv]
// Channel   Direction  Handshake            Payload
// input     in         in_valid, in_ready   kind, symbol
// output    out        out_valid, out_ready matched, pattern_overflowed
//
// Input transactions are taken on in_valid && in_ready; the row of position
// cells updates all active bits in that cycle, and a text byte can follow every cycle.
// An end-of-text transaction loads the single output register; the input stalls
// only while that register is full and out_ready is low.
// Reset is synchronous and leaves an empty pattern with only position zero active.

module wildcard_pattern_match (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       matched,
  output logic       pattern_overflowed
);

  wpm_pkg::idx_t  count;
  wpm_pkg::idx_t  count_next;
  wpm_pkg::idx_t  len;
  wpm_pkg::idx_t  len_next;
  logic           last_star;
  logic           last_star_next;
  logic           ovf;
  logic           ovf_next;
  logic           acc;
  logic           store;
  wpm_pkg::ctl_t  ctl;
  wpm_pkg::link_t link [0:wpm_pkg::MAX_PATTERN+1];
  logic [wpm_pkg::MAX_PATTERN:0] act;

  assign in_ready = !out_valid || out_ready;
  assign acc = in_valid && in_ready;

  // Runs of stars are kept as one stored star, so the star closure is one step deep.
  assign store = acc && (kind == wpm_pkg::KIND_APPEND) &&
                 (count < wpm_pkg::IDX_W'(wpm_pkg::MAX_PATTERN)) &&
                 !((symbol == wpm_pkg::SYM_STAR) && last_star);

  always_comb begin
    count_next = count;
    len_next = len;
    last_star_next = last_star;
    ovf_next = ovf;
    if (acc && (kind == wpm_pkg::KIND_CLEAR)) begin
      count_next = '0;
      len_next = '0;
      last_star_next = 1'b0;
      ovf_next = 1'b0;
    end else if (acc && (kind == wpm_pkg::KIND_APPEND)) begin
      if (count < wpm_pkg::IDX_W'(wpm_pkg::MAX_PATTERN)) begin
        count_next = count + 1'b1;
      end else begin
        ovf_next = 1'b1;
      end
      if (store) begin
        len_next = len + 1'b1;
        last_star_next = (symbol == wpm_pkg::SYM_STAR);
      end
    end
  end

  assign ctl.advance = acc && (kind == wpm_pkg::KIND_TEXT);
  assign ctl.restart = acc && (kind != wpm_pkg::KIND_TEXT);
  assign ctl.wr = store;
  assign ctl.sym = symbol;
  assign ctl.len = len;
  assign ctl.len_next = len_next;

  assign link[0] = '0;

  for (genvar i = 0; i <= wpm_pkg::MAX_PATTERN; i++) begin : g_cell
    wpm_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .idx   (wpm_pkg::IDX_W'(i)),
      .ctl   (ctl),
      .left  (link[i]),
      .right (link[i+1]),
      .act   (act[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      len <= '0;
      last_star <= 1'b0;
      ovf <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      len <= len_next;
      last_star <= last_star_next;
      ovf <= ovf_next;
      if (acc && (kind == wpm_pkg::KIND_END)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (kind == wpm_pkg::KIND_END)) begin
      matched <= act[len];
      pattern_overflowed <= ovf;
    end
  end

endmodule

[hw/rtl/wpm_checker.sv]
module wpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic       matched,
  input logic       pattern_overflowed
);

  logic acc;

  assign acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(matched) && $stable(pattern_overflowed))
    else $error("output payload changed while stalled");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    acc && (kind == wpm_pkg::KIND_END) |=> out_valid)
    else $error("end of text gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(acc && (kind == wpm_pkg::KIND_END)) |=> !out_valid)
    else $error("result without end of text");

  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    (acc && (kind == wpm_pkg::KIND_CLEAR)) ##1 (acc && (kind == wpm_pkg::KIND_END))
    |=> matched && !pattern_overflowed)
    else $error("empty text against empty pattern did not match");

endmodule

bind wildcard_pattern_match wpm_checker u_wpm_checker (.*);

[test/tb.sv]
module tb;

  typedef struct packed {
    logic matched;
    logic overflowed;
  } verdict_t;

  typedef struct packed {
    logic [1:0] k;
    logic [7:0] s;
    logic       typed;
    logic       m;
    logic       o;
  } row_t;

  localparam int NUM_ITEMS = 1300;
  localparam int LONG_HOLD = 120;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_C = 8'h63;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = wpm_pkg::KIND_CLEAR;
  logic [7:0] symbol = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       matched;
  logic       pattern_overflowed;

  wildcard_pattern_match uut (.*);

  always #2 clk = ~clk;

  logic [7:0]                    glob_pat [wpm_pkg::MAX_PATTERN];
  int unsigned                   glob_len = 0;
  logic                          glob_ovf = 1'b0;
  logic [wpm_pkg::MAX_PATTERN:0] glob_live;

  verdict_t verdicts [$];
  int items_sent = 0;
  int results_seen = 0;
  int matches_seen = 0;
  int overflow_seen = 0;
  int mismatches = 0;
  bit quiet = 1'b0;
  int holds_asked = 0;
  int holds_granted = 0;

  row_t directed_rows [24] = '{
    '{wpm_pkg::KIND_END,    8'h00,             1'b1, 1'b1, 1'b0},
    '{wpm_pkg::KIND_TEXT,   CH_A,              1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_END,    8'hFF,             1'b1, 1'b0, 1'b0},
    '{wpm_pkg::KIND_APPEND, wpm_pkg::SYM_STAR, 1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_END,    8'h00,             1'b1, 1'b1, 1'b0},
    '{wpm_pkg::KIND_TEXT,   8'hFF,             1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_TEXT,   8'h00,             1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_END,    8'h00,             1'b1, 1'b1, 1'b0},
    '{wpm_pkg::KIND_CLEAR,  8'hFF,             1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_APPEND, wpm_pkg::SYM_ANY,  1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_END,    8'h00,             1'b1, 1'b0, 1'b0},
    '{wpm_pkg::KIND_TEXT,   8'h00,             1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_END,    8'h00,             1'b1, 1'b1, 1'b0},
    '{wpm_pkg::KIND_APPEND, CH_A,              1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_TEXT,   CH_B,              1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_APPEND, CH_B,              1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_TEXT,   8'hFF,             1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_TEXT,   CH_A,              1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_TEXT,   CH_B,              1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_END,    8'h00,             1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_CLEAR,  8'h00,             1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_APPEND, 8'hFF,             1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_TEXT,   8'hFF,             1'b0, 1'b0, 1'b0},
    '{wpm_pkg::KIND_END,    8'h00,             1'b1, 1'b1, 1'b0}
  };

  function automatic void close_stars();
    for (int i = 0; i < int'(glob_len); i++) begin
      if (glob_live[i] && glob_pat[i] == wpm_pkg::SYM_STAR) begin
        glob_live[i + 1] = 1'b1;
      end
    end
  endfunction

  function automatic void rearm_text();
    glob_live = '0;
    glob_live[0] = 1'b1;
    close_stars();
  endfunction

  function automatic void step_text(logic [7:0] c);
    logic [wpm_pkg::MAX_PATTERN:0] nxt;
    nxt = '0;
    for (int i = 0; i < int'(glob_len); i++) begin
      if (glob_live[i]) begin
        if (glob_pat[i] == wpm_pkg::SYM_STAR) begin
          nxt[i] = 1'b1;
        end else if (glob_pat[i] == wpm_pkg::SYM_ANY || glob_pat[i] == c) begin
          nxt[i + 1] = 1'b1;
        end
      end
    end
    glob_live = nxt;
    close_stars();
  endfunction

  function automatic bit predict_match(logic [1:0] k, logic [7:0] s, output verdict_t v);
    v = '0;
    case (k)
      wpm_pkg::KIND_CLEAR: begin
        glob_len = 0;
        glob_ovf = 1'b0;
        rearm_text();
      end
      wpm_pkg::KIND_APPEND: begin
        if (glob_len < wpm_pkg::MAX_PATTERN) begin
          glob_pat[glob_len] = s;
          glob_len++;
        end else begin
          glob_ovf = 1'b1;
        end
        rearm_text();
      end
      wpm_pkg::KIND_TEXT: step_text(s);
      default: begin
        v.matched = glob_live[glob_len];
        v.overflowed = glob_ovf;
        rearm_text();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pattern_sym();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CH_A;
    if (r < 50) return CH_B;
    if (r < 70) return wpm_pkg::SYM_STAR;
    if (r < 88) return wpm_pkg::SYM_ANY;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_sym();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CH_A;
    if (r < 75) return CH_B;
    if (r < 90) return CH_C;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send(logic [1:0] k, logic [7:0] s, bit typed, verdict_t tv);
    int gap;
    verdict_t v;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    symbol <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (predict_match(k, s, v)) begin
      verdicts.push_back(typed ? tv : v);
    end
  endtask

  task automatic run_random();
    logic [7:0] pat_q [$];
    logic [7:0] txt_q [$];
    int seq_no;
    int plen;
    int cut;
    verdict_t none;
    none = '0;
    seq_no = 0;
    while (items_sent < NUM_ITEMS) begin
      if (seq_no % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (seq_no == 2 || seq_no % 30 == 17) holds_asked++;
      if (seq_no % 12 == 6) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (verdicts.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 6)) begin
          send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, none);
        end
      end else begin
        pat_q.delete();
        plen = (seq_no % 40 == 5) ?
               $urandom_range(wpm_pkg::MAX_PATTERN, wpm_pkg::MAX_PATTERN + 3)
               : $urandom_range(0, 8);
        send(wpm_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)), 1'b0, none);
        repeat (plen) begin
          pat_q.push_back(pattern_sym());
          send(wpm_pkg::KIND_APPEND, pat_q[$], 1'b0, none);
        end
        repeat (plen > 8 ? 1 : $urandom_range(1, 4)) begin
          txt_q.delete();
          foreach (pat_q[i]) begin
            if (pat_q[i] == wpm_pkg::SYM_STAR) begin
              repeat ($urandom_range(0, 3)) txt_q.push_back(text_sym());
            end else if (pat_q[i] == wpm_pkg::SYM_ANY) begin
              txt_q.push_back(text_sym());
            end else begin
              txt_q.push_back(pat_q[i]);
            end
          end
          if ($urandom_range(0, 99) < 30) begin
            case ($urandom_range(0, 2))
              0: if (txt_q.size() > 0) txt_q[$urandom_range(0, txt_q.size() - 1)] = text_sym();
              1: if (txt_q.size() > 0) txt_q.delete($urandom_range(0, txt_q.size() - 1));
              default: txt_q.insert($urandom_range(0, txt_q.size()), text_sym());
            endcase
          end
          // Occasionally the pattern grows in the middle of a text.
          cut = ($urandom_range(0, 99) < 6) ? $urandom_range(0, txt_q.size()) : -1;
          foreach (txt_q[i]) begin
            if (i == cut) send(wpm_pkg::KIND_APPEND, pattern_sym(), 1'b0, none);
            send(wpm_pkg::KIND_TEXT, txt_q[i], 1'b0, none);
          end
          send(wpm_pkg::KIND_END, 8'($urandom_range(0, 255)), 1'b0, none);
        end
      end
      seq_no++;
    end
  endtask

  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (holds_granted < holds_asked) begin
        holds_granted++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result transaction: matched=%0b pattern_overflowed=%0b",
                   matched, pattern_overflowed);
        end
      end else begin
        want = verdicts.pop_front();
        matches_seen += int'(matched);
        overflow_seen += int'(pattern_overflowed);
        if (matched !== want.matched || pattern_overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected matched=%0b pattern_overflowed=%0b, got %0b %0b",
                     want.matched, want.overflowed, matched, pattern_overflowed);
          end
        end
      end
    end
  end

  initial begin
    verdict_t tv;
    rearm_text();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      tv.matched = directed_rows[i].m;
      tv.overflowed = directed_rows[i].o;
      send(directed_rows[i].k, directed_rows[i].s, directed_rows[i].typed, tv);
    end
    run_random();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d input transactions and checked %0d results.", items_sent, results_seen);
    $display("Of those results, %0d matched and %0d reported a truncated pattern.",
             matches_seen, overflow_seen);
    if (mismatches == 0 && verdicts.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/wpm_pkg.sv
hw/rtl/wpm_cell.sv
hw/rtl/wildcard_pattern_match.sv
hw/rtl/wpm_checker.sv
test/tb.sv
